### rtl/core/dtf_pkg.sv
// Package for the decimal text to float core.
// Holds character codes, scaling tables and state types; no dependencies.
package dtf_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;

  // Limits and widths
  localparam int unsigned MANT_W = 31;
  localparam logic [MANT_W-1:0] MANT_LIMIT = 31'd200000000;
  localparam logic [13:0] EXP_DIGIT_MAX = 14'd9999;
  localparam logic [15:0] COUNT_MAX = 16'hffff;
  localparam logic signed [15:0] EXP_BIAS = 16'sd150;
  localparam logic signed [15:0] DEC_MAX = 16'sh7fff;
  localparam logic signed [15:0] DEC_MIN = 16'sh8000;
  localparam logic [2:0] STEP_LAST = 3'd5;

  // Text parser modes
  typedef enum logic [4:0] {
    MODE_SIGN  = 5'b00001,
    MODE_INT   = 5'b00010,
    MODE_FRAC  = 5'b00100,
    MODE_ESIGN = 5'b01000,
    MODE_EDIG  = 5'b10000
  } parse_mode_t;

  // Conversion sequencer
  typedef enum logic [5:0] {
    SEQ_IDLE = 6'b000001,
    SEQ_NORM = 6'b000010,
    SEQ_STEP = 6'b000100,
    SEQ_ADJ  = 6'b001000,
    SEQ_SHR  = 6'b010000,
    SEQ_PACK = 6'b100000
  } seq_state_t;

  // Multiplier for a multiply-by-ten step group (Q31 style fraction)
  function automatic logic [31:0] up_scale(input logic [2:0] idx);
    case (idx)
      3'd0:    up_scale = 32'd1342177280;
      3'd1:    up_scale = 32'd1677721600;
      3'd2:    up_scale = 32'd2097152000;
      3'd3:    up_scale = 32'd2048000000;
      3'd4:    up_scale = 32'd1953125000;
      3'd5:    up_scale = 32'd1776356839;
      default: up_scale = 32'd0;
    endcase
  endfunction

  // Multiplier for a divide-by-ten step group
  function automatic logic [31:0] down_scale(input logic [2:0] idx);
    case (idx)
      3'd0:    down_scale = 32'd1717986918;
      3'd1:    down_scale = 32'd1374389535;
      3'd2:    down_scale = 32'd1099511628;
      3'd3:    down_scale = 32'd1125899907;
      3'd4:    down_scale = 32'd1180591621;
      3'd5:    down_scale = 32'd1298074215;
      default: down_scale = 32'd0;
    endcase
  endfunction

  // Binary exponent gained when scaling up
  function automatic logic signed [15:0] up_bits(input logic [2:0] idx);
    case (idx)
      3'd0:    up_bits = 16'sd4;
      3'd1:    up_bits = 16'sd7;
      3'd2:    up_bits = 16'sd10;
      3'd3:    up_bits = 16'sd20;
      3'd4:    up_bits = 16'sd40;
      3'd5:    up_bits = 16'sd80;
      default: up_bits = 16'sd0;
    endcase
  endfunction

  // Binary exponent lost when scaling down
  function automatic logic signed [15:0] down_bits(input logic [2:0] idx);
    case (idx)
      3'd0:    down_bits = 16'sd3;
      3'd1:    down_bits = 16'sd6;
      3'd2:    down_bits = 16'sd9;
      3'd3:    down_bits = 16'sd19;
      3'd4:    down_bits = 16'sd39;
      3'd5:    down_bits = 16'sd79;
      default: down_bits = 16'sd0;
    endcase
  endfunction

  // Decimal exponent covered by each step
  function automatic logic [16:0] dec_steps(input logic [2:0] idx);
    case (idx)
      3'd0:    dec_steps = 17'd1;
      3'd1:    dec_steps = 17'd2;
      3'd2:    dec_steps = 17'd3;
      3'd3:    dec_steps = 17'd6;
      3'd4:    dec_steps = 17'd12;
      3'd5:    dec_steps = 17'd24;
      default: dec_steps = 17'd0;
    endcase
  endfunction

endpackage

### rtl/core/decimal_text_to_float_core.sv
// Decimal text to IEEE single converter, top level.
// Depends on dtf_pkg (codes, scale tables, state types).
//
// Usage:
//  - Input channel (in_valid/in_ready/in_char_code) takes one text character
//    per request. NUL or any unexpected character ends the number and is
//    counted.
//  - On the terminator a shared sequencer converts the value: one left shift
//    a cycle to normalize (up to 30), then six table step checks, every
//    taken step going through one 31x32 multiplier, then up to 7 right
//    shifts, then the pack state. After the terminator in_ready stays low
//    until the pack state completes (a zero mantissa goes straight to pack),
//    longer while the pack state waits for the output register.
//  - Output channel (out_valid/out_ready/out_float_bits/out_chars_consumed)
//    is a register; while a result waits, characters of the next number are
//    still accepted. The pack cycle holds until that register is free.
//  - Zero mantissa gives float_bits 0 with no scaling work.
//  - Synchronous active-low reset clears the parser, the sequencer and
//    out_valid.
module decimal_text_to_float_core
  import dtf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_float_bits,
  output logic [15:0] out_chars_consumed
);

  // Parser state
  parse_mode_t        mode_r, mode_nxt;
  logic [MANT_W-1:0]  mant_acc_r, mant_acc_nxt;
  logic signed [15:0] dec_exp_r, dec_exp_nxt;
  logic [13:0]        exp_dig_r, exp_dig_nxt;
  logic               neg_r, neg_nxt;
  logic               exp_neg_r, exp_neg_nxt;
  logic [15:0]        char_cnt_r, char_cnt_nxt;

  // Conversion state
  seq_state_t         seq_r, seq_nxt;
  logic [MANT_W-1:0]  man_r, man_nxt;
  logic signed [15:0] exp2_r, exp2_nxt;
  logic [16:0]        e_rem_r, e_rem_nxt;
  logic               dir_up_r, dir_up_nxt;
  logic               sign_r, sign_nxt;
  logic               zero_r, zero_nxt;
  logic [15:0]        count_r, count_nxt;
  logic [2:0]         idx_r, idx_nxt;
  logic [29:0]        prod_hi_r, prod_hi_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_bits_r, out_bits_nxt;
  logic [15:0]        out_cnt_r, out_cnt_nxt;

  logic               accept;
  logic               is_digit;
  logic [3:0]         digit;
  logic               done;
  logic [33:0]        mant_x10;
  logic [16:0]        exp_x10;
  logic signed [17:0] e10_wide;
  logic signed [15:0] e10;
  logic [31:0]        scale;
  logic [62:0]        product;
  logic [MANT_W-1:0]  adj_man;
  logic signed [15:0] exp_biased;

  assign in_ready = (seq_r == SEQ_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_digit = in_char_code inside {[CH_ZERO:CH_NINE]};
  assign digit    = in_char_code[3:0];
  assign mant_x10 = {mant_acc_r, 3'b000} + {2'b00, mant_acc_r, 1'b0} + {30'd0, digit};
  assign exp_x10  = {exp_dig_r, 3'b000} + {2'b00, exp_dig_r, 1'b0} + {13'd0, digit};

  // Character parser
  always_comb begin
    mode_nxt     = mode_r;
    mant_acc_nxt = mant_acc_r;
    dec_exp_nxt  = dec_exp_r;
    exp_dig_nxt  = exp_dig_r;
    neg_nxt      = neg_r;
    exp_neg_nxt  = exp_neg_r;
    done         = 1'b0;
    char_cnt_nxt = (char_cnt_r == COUNT_MAX) ? char_cnt_r : char_cnt_r + 16'd1;
    if (in_char_code == CH_NUL) begin
      done = 1'b1;
    end else begin
      case (mode_r)
        MODE_SIGN: begin
          mode_nxt = MODE_INT;
          if (is_digit) begin
            mant_acc_nxt = {27'd0, digit};
          end else if (in_char_code == CH_MINUS) begin
            neg_nxt = 1'b1;
          end else if (in_char_code == CH_POINT) begin
            mode_nxt = MODE_FRAC;
          end else if (in_char_code != CH_PLUS) begin
            done = 1'b1;
          end
        end
        MODE_INT: begin
          if (is_digit) begin
            if (mant_acc_r <= MANT_LIMIT) begin
              mant_acc_nxt = mant_x10[MANT_W-1:0];
            end else if (dec_exp_r != DEC_MAX) begin
              dec_exp_nxt = dec_exp_r + 16'sd1;
            end
          end else if (in_char_code == CH_POINT) begin
            mode_nxt = MODE_FRAC;
          end else if (in_char_code == CH_LO_E || in_char_code == CH_UP_E) begin
            mode_nxt = MODE_ESIGN;
          end else begin
            done = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (is_digit) begin
            if (mant_acc_r <= MANT_LIMIT) begin
              mant_acc_nxt = mant_x10[MANT_W-1:0];
              if (dec_exp_r != DEC_MIN) begin
                dec_exp_nxt = dec_exp_r - 16'sd1;
              end
            end
          end else if (in_char_code == CH_LO_E || in_char_code == CH_UP_E) begin
            mode_nxt = MODE_ESIGN;
          end else begin
            done = 1'b1;
          end
        end
        MODE_ESIGN: begin
          mode_nxt = MODE_EDIG;
          if (is_digit) begin
            exp_dig_nxt = {10'd0, digit};
          end else if (in_char_code == CH_MINUS) begin
            exp_neg_nxt = 1'b1;
          end else if (in_char_code != CH_PLUS) begin
            done = 1'b1;
          end
        end
        default: begin
          if (is_digit) begin
            exp_dig_nxt = (exp_x10 > {3'd0, EXP_DIGIT_MAX}) ? EXP_DIGIT_MAX
                                                           : exp_x10[13:0];
          end else begin
            done = 1'b1;
          end
        end
      endcase
    end
  end

  // Combined decimal exponent, saturated to 16 bits
  always_comb begin
    if (exp_neg_r) begin
      e10_wide = 18'(dec_exp_r) - $signed({4'd0, exp_dig_r});
    end else begin
      e10_wide = 18'(dec_exp_r) + $signed({4'd0, exp_dig_r});
    end
    if (e10_wide > 18'sd32767) begin
      e10 = DEC_MAX;
    end else if (e10_wide < -18'sd32768) begin
      e10 = DEC_MIN;
    end else begin
      e10 = e10_wide[15:0];
    end
  end

  // Shared multiplier and renormalize after a step
  assign scale   = dir_up_r ? up_scale(idx_r) : down_scale(idx_r);
  assign product = {32'd0, man_r} * {31'd0, scale};

  always_comb begin
    adj_man = {prod_hi_r, 1'b0};
    if (!adj_man[30]) begin
      adj_man = {adj_man[29:0], 1'b0};
    end
  end

  assign exp_biased = exp2_r + EXP_BIAS;

  // Conversion sequencer
  always_comb begin
    seq_nxt       = seq_r;
    man_nxt       = man_r;
    exp2_nxt      = exp2_r;
    e_rem_nxt     = e_rem_r;
    dir_up_nxt    = dir_up_r;
    sign_nxt      = sign_r;
    zero_nxt      = zero_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    prod_hi_nxt   = prod_hi_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_bits_nxt  = out_bits_r;
    out_cnt_nxt   = out_cnt_r;
    case (seq_r)
      SEQ_IDLE: begin
        if (accept && done) begin
          man_nxt    = mant_acc_r;
          exp2_nxt   = 16'sd0;
          sign_nxt   = neg_r;
          count_nxt  = char_cnt_nxt;
          zero_nxt   = (mant_acc_r == '0);
          dir_up_nxt = (e10 > 16'sd0);
          e_rem_nxt  = (e10 > 16'sd0) ? 17'(e10) : 17'd0 - 17'(e10);
          idx_nxt    = STEP_LAST;
          seq_nxt    = (mant_acc_r == '0) ? SEQ_PACK : SEQ_NORM;
        end
      end
      SEQ_NORM: begin
        if (man_r[30]) begin
          seq_nxt = SEQ_STEP;
        end else begin
          man_nxt  = {man_r[29:0], 1'b0};
          exp2_nxt = exp2_r - 16'sd1;
        end
      end
      SEQ_STEP: begin
        if (e_rem_r >= dec_steps(idx_r)) begin
          prod_hi_nxt = product[61:32];
          seq_nxt     = SEQ_ADJ;
        end else if (idx_r == 3'd0) begin
          seq_nxt = SEQ_SHR;
        end else begin
          idx_nxt = idx_r - 3'd1;
        end
      end
      SEQ_ADJ: begin
        man_nxt   = adj_man;
        e_rem_nxt = e_rem_r - dec_steps(idx_r);
        exp2_nxt  = exp2_r + (dir_up_r ? up_bits(idx_r) : -down_bits(idx_r))
                    - (({prod_hi_r, 1'b0} & 31'h4000_0000) == '0 ? 16'sd1 : 16'sd0);
        if (idx_r == 3'd0) begin
          seq_nxt = SEQ_SHR;
        end else begin
          idx_nxt = idx_r - 3'd1;
          seq_nxt = SEQ_STEP;
        end
      end
      SEQ_SHR: begin
        if (man_r[30:24] != '0) begin
          man_nxt  = {1'b0, man_r[30:1]};
          exp2_nxt = exp2_r + 16'sd1;
        end else begin
          seq_nxt = SEQ_PACK;
        end
      end
      SEQ_PACK: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = count_r;
          if (zero_r) begin
            out_bits_nxt = 32'd0;
          end else begin
            out_bits_nxt = {sign_r | exp_biased[8], exp_biased[7:0], man_r[22:0]};
          end
          seq_nxt = SEQ_IDLE;
        end
      end
      default: begin
        seq_nxt = SEQ_IDLE;
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_SIGN;
      mant_acc_r  <= '0;
      dec_exp_r   <= '0;
      exp_dig_r   <= '0;
      neg_r       <= 1'b0;
      exp_neg_r   <= 1'b0;
      char_cnt_r  <= '0;
      seq_r       <= SEQ_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        if (done) begin
          mode_r     <= MODE_SIGN;
          mant_acc_r <= '0;
          dec_exp_r  <= '0;
          exp_dig_r  <= '0;
          neg_r      <= 1'b0;
          exp_neg_r  <= 1'b0;
          char_cnt_r <= '0;
        end else begin
          mode_r     <= mode_nxt;
          mant_acc_r <= mant_acc_nxt;
          dec_exp_r  <= dec_exp_nxt;
          exp_dig_r  <= exp_dig_nxt;
          neg_r      <= neg_nxt;
          exp_neg_r  <= exp_neg_nxt;
          char_cnt_r <= char_cnt_nxt;
        end
      end
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    man_r      <= man_nxt;
    exp2_r     <= exp2_nxt;
    e_rem_r    <= e_rem_nxt;
    dir_up_r   <= dir_up_nxt;
    sign_r     <= sign_nxt;
    zero_r     <= zero_nxt;
    count_r    <= count_nxt;
    idx_r      <= idx_nxt;
    prod_hi_r  <= prod_hi_nxt;
    out_bits_r <= out_bits_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_float_bits     = out_bits_r;
  assign out_chars_consumed = out_cnt_r;

endmodule

### sim/decimal_text_to_float_core_test.sv
// Testbench for decimal_text_to_float_core: drives text characters as requests and
// checks each float result against an in-bench parser and converter model.
// Depends on dtf_pkg (character codes, parser mode type) and the core RTL.
module decimal_text_to_float_core_test;
  import dtf_pkg::*;

  // Scaling tables, index 0 is the smallest step
  localparam logic [5:0][31:0] UP_MUL = {32'd1776356839, 32'd1953125000, 32'd2048000000,
                                         32'd2097152000, 32'd1677721600, 32'd1342177280};
  localparam logic [5:0][31:0] DOWN_MUL = {32'd1298074215, 32'd1180591621, 32'd1125899907,
                                           32'd1099511628, 32'd1374389535, 32'd1717986918};
  localparam logic [5:0][7:0] UP_SHIFT   = {8'd80, 8'd40, 8'd20, 8'd10, 8'd7, 8'd4};
  localparam logic [5:0][7:0] DOWN_SHIFT = {8'd79, 8'd39, 8'd19, 8'd9, 8'd6, 8'd3};
  localparam logic [5:0][7:0] DEC_STEP   = {8'd24, 8'd12, 8'd6, 8'd3, 8'd2, 8'd1};

  localparam logic [30:0] MANT_KEEP_MAX = 31'd200000000;
  localparam int          EXP_DIG_TOP   = 9999;
  localparam logic [15:0] COUNT_TOP     = 16'hffff;
  localparam int          MAX_REPORTS   = 10;

  typedef struct packed {
    logic [31:0] float_bits;
    logic [15:0] chars_consumed;
  } single_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_code = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_float_bits;
  logic [15:0] out_chars_consumed;

  // Text parser copy
  parse_mode_t txt_mode;
  logic [30:0] txt_mant;
  int          txt_dec_exp;
  int          txt_exp_digits;
  logic        txt_neg;
  logic        txt_exp_neg;
  logic [15:0] txt_count;

  single_result_t expected_singles[$];
  single_result_t oldest_single;
  int          fail_count = 0;
  int unsigned chars_sent = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int unsigned receiver_hold_req = 0;
  int unsigned hold_left = 0;

  decimal_text_to_float_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_char_code       (in_char_code),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_float_bits     (out_float_bits),
    .out_chars_consumed (out_chars_consumed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic clear_text();
    txt_mode = MODE_SIGN;
    txt_mant = '0;
    txt_dec_exp = 0;
    txt_exp_digits = 0;
    txt_neg = 1'b0;
    txt_exp_neg = 1'b0;
    txt_count = '0;
  endtask

  // Normalize, one six-step power-of-ten pass, truncate to 24 bits, pack
  function automatic logic [31:0] single_bits();
    logic [31:0] man;
    logic [31:0] mul;
    logic [63:0] prod;
    int          exp2;
    int          e10;
    int          e;
    logic        up;
    man = {1'b0, txt_mant};
    if (man == 32'd0) return 32'd0;
    e10 = txt_exp_neg ? txt_dec_exp - txt_exp_digits : txt_dec_exp + txt_exp_digits;
    e10 = clamp16(e10);
    exp2 = 0;
    while (!man[30]) begin
      man = man << 1;
      exp2--;
    end
    up = (e10 > 0);
    e = up ? e10 : -e10;
    for (int i = 5; i >= 0; i--) begin
      if (e >= int'(DEC_STEP[i])) begin
        mul = up ? UP_MUL[i] : DOWN_MUL[i];
        prod = {32'd0, man} * {32'd0, mul};
        // upper word doubled, bit 31 dropped
        man = {1'b0, prod[61:32], 1'b0};
        e -= int'(DEC_STEP[i]);
        if (up) exp2 += int'(UP_SHIFT[i]);
        else exp2 -= int'(DOWN_SHIFT[i]);
        if (!man[30]) begin
          man = {1'b0, man[29:0], 1'b0};
          exp2--;
        end
      end
    end
    while (man[31:24] != 8'd0) begin
      man = man >> 1;
      exp2++;
    end
    return {txt_neg, 31'd0} | (32'(exp2 + 150) << 23) | (man & 32'h007f_ffff);
  endfunction

  // Advance the parser by one accepted character; queue a result on a terminator
  task automatic predict_char(input logic [7:0] ch);
    logic           is_dig;
    logic [3:0]     dig;
    logic           done;
    single_result_t r;
    is_dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
    dig = 4'(ch - CH_ZERO);
    done = 1'b0;
    if (txt_count != COUNT_TOP) txt_count++;
    if (ch == CH_NUL) begin
      done = 1'b1;
    end else begin
      case (txt_mode)
        MODE_SIGN: begin
          if (is_dig) txt_mant = 31'(dig);
          else if (ch == CH_MINUS) txt_neg = 1'b1;
          else if (ch == CH_POINT) txt_mode = MODE_FRAC;
          else if (ch != CH_PLUS) done = 1'b1;
          if (txt_mode == MODE_SIGN) txt_mode = MODE_INT;
        end
        MODE_INT: begin
          if (is_dig) begin
            if (txt_mant <= MANT_KEEP_MAX) txt_mant = txt_mant * 31'd10 + 31'(dig);
            else txt_dec_exp = clamp16(txt_dec_exp + 1);
          end else if (ch == CH_POINT) txt_mode = MODE_FRAC;
          else if (ch == CH_LO_E || ch == CH_UP_E) txt_mode = MODE_ESIGN;
          else done = 1'b1;
        end
        MODE_FRAC: begin
          if (is_dig) begin
            // digits past the kept mantissa are dropped
            if (txt_mant <= MANT_KEEP_MAX) begin
              txt_mant = txt_mant * 31'd10 + 31'(dig);
              txt_dec_exp = clamp16(txt_dec_exp - 1);
            end
          end else if (ch == CH_LO_E || ch == CH_UP_E) txt_mode = MODE_ESIGN;
          else done = 1'b1;
        end
        MODE_ESIGN: begin
          if (is_dig) txt_exp_digits = int'(dig);
          else if (ch == CH_MINUS) txt_exp_neg = 1'b1;
          else if (ch != CH_PLUS) done = 1'b1;
          txt_mode = MODE_EDIG;
        end
        default: begin
          if (is_dig) begin
            txt_exp_digits = txt_exp_digits * 10 + int'(dig);
            if (txt_exp_digits > EXP_DIG_TOP) txt_exp_digits = EXP_DIG_TOP;
          end else done = 1'b1;
        end
      endcase
    end
    if (done) begin
      r.float_bits = single_bits();
      r.chars_consumed = txt_count;
      expected_singles.push_back(r);
      clear_text();
    end
  endtask

  task automatic note_error(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  // Offer one character request; returns at the falling edge after acceptance
  task automatic send_char(input logic [7:0] ch);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_char(ch);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(CH_NUL);
  endtask

  task automatic send_digits(input int unsigned n);
    repeat (n) send_char(CH_ZERO + 8'($urandom_range(9)));
  endtask

  // Sender stops and waits until every queued result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_singles.size() != 0) @(negedge clk);
  endtask

  // Mostly well-formed numbers with random content, some noise
  task automatic send_random_number();
    int unsigned n;
    if ($urandom_range(99) < 12) begin
      n = $urandom_range(1, 8);
      repeat (n) send_char(8'($urandom_range(255)));
      send_char(CH_NUL);
    end else begin
      case ($urandom_range(3))
        0: send_char(CH_MINUS);
        1: send_char(CH_PLUS);
        default: ;
      endcase
      n = ($urandom_range(9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
      send_digits(n);
      if ($urandom_range(2) != 0) begin
        send_char(CH_POINT);
        n = ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 6);
        send_digits(n);
      end
      if ($urandom_range(1) != 0) begin
        send_char($urandom_range(1) ? CH_LO_E : CH_UP_E);
        case ($urandom_range(2))
          0: send_char(CH_MINUS);
          1: send_char(CH_PLUS);
          default: ;
        endcase
        n = ($urandom_range(7) == 0) ? $urandom_range(3, 5) : $urandom_range(1, 2);
        send_digits(n);
      end
      // a stray character may end the number or run into the next one
      send_char(($urandom_range(4) != 0) ? CH_NUL : 8'($urandom_range(1, 255)));
    end
  endtask

  task automatic test_directed();
    send_text("0");
    send_text("-0");
    send_text("+1.5");
    send_text("-123.25e+2");
    send_text(".5");
    send_text("1E-5");
    send_text("3.4e38");
    send_text("1e50");
    send_text("1e-60");
    send_text("1e99999");
    send_text("2000000019999");
    send_text("0.000123456789123");
    send_text("4294967295");
    send_text("0e5");
    send_text(" 1");
    send_text("e5");
    send_text("1x");
    send_text("1.2.3");
    send_text("1e");
    send_text("7e-");
    send_text("5ex");
    send_text("4e+7q");
    send_text("-");
    send_text(".");
    send_text("");
    // all-ones character ends the number
    send_char(CH_NINE);
    send_char(8'hff);
  endtask

  task automatic test_random(input int unsigned n);
    int unsigned start;
    start = chars_sent;
    while (chars_sent - start < n) send_random_number();
    send_char(CH_NUL);
  endtask

  // Receiver holds off while numbers keep coming, so the core backs up
  task automatic test_backpressure();
    receiver_hold_req = 400;
    repeat (4) send_text("98765.4321e-7");
    send_text("-1e3");
    send_text("123456789012e-20");
    wait_drained();
  endtask

  // Long integer part: digits past the kept mantissa raise the exponent
  task automatic test_long_number();
    send_char(CH_ZERO + 8'd1);
    repeat (40) send_char(CH_NINE);
    send_text("e9999");
    send_text("9999999999999999999999999.5e-9999");
  endtask

  // Receiver ready, with a counted hold-off on request
  always @(negedge clk) begin
    if (receiver_hold_req != 0) begin
      hold_left = receiver_hold_req;
      receiver_hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_singles.size() == 0) begin
        note_error($sformatf("unexpected result bits=%h count=%0d",
                             out_float_bits, out_chars_consumed));
      end else begin
        oldest_single = expected_singles.pop_front();
        if (out_float_bits !== oldest_single.float_bits)
          note_error($sformatf("float_bits expected %h got %h",
                               oldest_single.float_bits, out_float_bits));
        if (out_chars_consumed !== oldest_single.chars_consumed)
          note_error($sformatf("chars_consumed expected %0d got %0d",
                               oldest_single.chars_consumed, out_chars_consumed));
      end
    end
  end

  initial begin
    clear_text();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_gap_pct = 15;
    recv_gap_pct = 66;
    test_directed();
    test_random(480);
    test_backpressure();

    send_gap_pct = 66;
    recv_gap_pct = 15;
    test_random(480);

    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_long_number();
    test_random(480);

    wait_drained();
    repeat (60) @(negedge clk);
    if (fail_count == 0 && expected_singles.size() == 0) begin
      $display("decimal_text_to_float_core_test: PASS");
    end else begin
      $display("decimal_text_to_float_core_test: FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #8000000;
    $display("decimal_text_to_float_core_test: FAIL");
    $finish;
  end

endmodule
